>>> sv/tpc_pkg.sv
// ----------------------------------------------------------------------------
// tpc_pkg: shared types and constants of the triangle plane clipper
// Register map, fixed field widths and the control word handed to the merge.
// ----------------------------------------------------------------------------
package tpc_pkg;

    // Fixed field widths
    localparam int NRM_W  = 18;
    localparam int OFS_W  = 20;
    localparam int TAG_W  = 16;
    localparam int SLOT_W = 2;
    localparam int SIZE_W = 3;
    localparam int ADDR_W = 4;

    // Number of vertices and edges of a triangle
    localparam int NUM_LANES = 3;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_NORMAL_X = 2'd0;
    localparam logic [1:0] REG_NORMAL_Y = 2'd1;
    localparam logic [1:0] REG_NORMAL_Z = 2'd2;
    localparam logic [1:0] REG_OFFSET   = 2'd3;

    // Reset values
    localparam logic signed [NRM_W-1:0] NORMAL_X_RST = 18'sd0;
    localparam logic signed [NRM_W-1:0] NORMAL_Y_RST = 18'sd65536;
    localparam logic signed [NRM_W-1:0] NORMAL_Z_RST = 18'sd0;
    localparam logic signed [OFS_W-1:0] OFFSET_RST   = 20'sd65536;

    // Control word that travels with a triangle into the merge stage
    typedef struct packed {
        logic       vld;
        logic [2:0] in_mask;
    } tpc_ctl_t;

endpackage

>>> sv/tpc_dist.sv
// ----------------------------------------------------------------------------
// tpc_dist: signed plane distance of one vertex
// Two stages: three normal products, then the sum minus the scaled offset.
// ----------------------------------------------------------------------------
module tpc_dist
    import tpc_pkg::*;
#(
    parameter int CW = 20,
    parameter int DW = 46
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [NRM_W-1:0] nrm [3],
    input  logic signed [OFS_W-1:0] ofs,
    input  logic signed [CW-1:0]    p [3],
    output logic signed [DW-1:0]    d
);

    logic signed [NRM_W+CW-1:0] prod_reg [3];
    logic signed [OFS_W-1:0]    ofs_reg;
    logic signed [DW-1:0]       d_reg;
    logic signed [DW-1:0]       d_next;

    // Multiply each coordinate by its normal component
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                prod_reg[k] <= nrm[k] * p[k];
            end
            ofs_reg <= ofs;
        end
    end

    // Sum the products and remove the offset in Q.32
    always_comb begin
        d_next = DW'(prod_reg[0]) + DW'(prod_reg[1]) + DW'(prod_reg[2])
               - (DW'(ofs_reg) <<< 16);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign d = d_reg;

endmodule

>>> sv/tpc_edge.sv
// ----------------------------------------------------------------------------
// tpc_edge: intersection of one triangle edge with the plane
// Computes a + round((b-a)*da/(da-db)) per axis, saturated, through a
// magnitude stage, a split multiply, and one quotient bit per stage.
// ----------------------------------------------------------------------------
module tpc_edge
    import tpc_pkg::*;
#(
    parameter int CW = 20,
    parameter int DW = 46
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [CW-1:0] a [3],
    input  logic signed [CW-1:0] b [3],
    input  logic signed [DW-1:0] da,
    input  logic signed [DW-1:0] db,
    output logic signed [CW-1:0] x [3]
);

    localparam int QW  = CW + 1;
    localparam int LOW = DW / 2;
    localparam int HIW = DW - LOW;
    localparam int PW  = CW + 1 + DW;
    localparam int NMW = PW + 2;
    localparam int RW  = DW + 2;

    localparam logic signed [CW+1:0] SMAX = {3'b000, {(CW-1){1'b1}}};
    localparam logic signed [CW+1:0] SMIN = {3'b111, {(CW-1){1'b0}}};

    // Magnitude stage
    logic signed [CW:0]   diff [3];
    logic signed [DW:0]   den;
    logic [CW:0]          um_reg [3];
    logic                 neg1_reg [3];
    logic signed [CW-1:0] a1_reg [3];
    logic [DW-1:0]        ud_reg;
    logic [DW:0]          uden1_reg;

    always_comb begin
        den = (DW+1)'(da) - (DW+1)'(db);
        for (int k = 0; k < 3; k++) begin
            diff[k] = (CW+1)'(b[k]) - (CW+1)'(a[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                um_reg[k]   <= diff[k][CW] ? (CW+1)'(-diff[k]) : (CW+1)'(diff[k]);
                neg1_reg[k] <= diff[k][CW] ^ da[DW-1] ^ den[DW];
                a1_reg[k]   <= a[k];
            end
            ud_reg    <= da[DW-1] ? DW'(-da) : DW'(da);
            uden1_reg <= den[DW] ? (DW+1)'(-den) : (DW+1)'(den);
        end
    end

    // Split multiply of |b-a| by |da|
    logic [CW+LOW:0]      plo_reg [3];
    logic [CW+HIW:0]      phi_reg [3];
    logic                 neg2_reg [3];
    logic signed [CW-1:0] a2_reg [3];
    logic [DW:0]          uden2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                plo_reg[k]  <= um_reg[k] * ud_reg[LOW-1:0];
                phi_reg[k]  <= um_reg[k] * ud_reg[DW-1:LOW];
                neg2_reg[k] <= neg1_reg[k];
                a2_reg[k]   <= a1_reg[k];
            end
            uden2_reg <= uden1_reg;
        end
    end

    // Divider pipeline: stage 0 holds the prepared numerator
    logic [RW-1:0]        rem_reg  [QW+1][3];
    logic [QW-1:0]        bits_reg [QW+1][3];
    logic [QW-1:0]        q_reg    [QW+1][3];
    logic                 neg_reg  [QW+1][3];
    logic signed [CW-1:0] ax_reg   [QW+1][3];
    logic [RW-1:0]        dv_reg   [QW+1];

    logic [PW-1:0]  prod [3];
    logic [NMW-1:0] num  [3];

    // Form 2*N + den so that the floor quotient rounds half away from zero
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            prod[k] = {phi_reg[k], {LOW{1'b0}}} + PW'(plo_reg[k]);
            num[k]  = {1'b0, prod[k], 1'b0} + NMW'(uden2_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                rem_reg[0][k]  <= num[k][NMW-1:QW];
                bits_reg[0][k] <= num[k][QW-1:0];
                q_reg[0][k]    <= '0;
                neg_reg[0][k]  <= neg2_reg[k];
                ax_reg[0][k]   <= a2_reg[k];
            end
            dv_reg[0] <= {uden2_reg, 1'b0};
        end
    end

    // One restoring quotient bit per stage
    for (genvar s = 0; s < QW; s++) begin : g_div
        logic [RW:0] trial [3];
        logic        ge    [3];

        always_comb begin
            for (int k = 0; k < 3; k++) begin
                trial[k] = {rem_reg[s][k], bits_reg[s][k][QW-1]};
                ge[k]    = (trial[k] >= {1'b0, dv_reg[s]});
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int k = 0; k < 3; k++) begin
                    rem_reg[s+1][k]  <= ge[k] ? RW'(trial[k] - {1'b0, dv_reg[s]})
                                              : RW'(trial[k]);
                    bits_reg[s+1][k] <= bits_reg[s][k] << 1;
                    q_reg[s+1][k]    <= {q_reg[s][k][QW-2:0], ge[k]};
                    neg_reg[s+1][k]  <= neg_reg[s][k];
                    ax_reg[s+1][k]   <= ax_reg[s][k];
                end
                dv_reg[s+1] <= dv_reg[s];
            end
        end
    end

    // Apply the step to a and saturate
    logic signed [CW+1:0] sum [3];
    logic signed [CW-1:0] x_reg [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (neg_reg[QW][k]) begin
                sum[k] = (CW+2)'(ax_reg[QW][k]) - $signed({1'b0, q_reg[QW][k]});
            end else begin
                sum[k] = (CW+2)'(ax_reg[QW][k]) + $signed({1'b0, q_reg[QW][k]});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                if (sum[k] > SMAX) begin
                    x_reg[k] <= CW'(SMAX);
                end else if (sum[k] < SMIN) begin
                    x_reg[k] <= CW'(SMIN);
                end else begin
                    x_reg[k] <= CW'(sum[k]);
                end
            end
        end
    end

    assign x = x_reg;

endmodule

>>> sv/tpc_merge.sv
// ----------------------------------------------------------------------------
// tpc_merge: polygon assembly and result serializer
// Combines the edge lanes into a 0..4 vertex polygon and sends it out
// one vertex word at a time.
// ----------------------------------------------------------------------------
module tpc_merge
    import tpc_pkg::*;
#(
    parameter int CW = 20
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tpc_ctl_t             ctl,
    input  logic signed [CW-1:0] vert [3][3],
    input  logic signed [CW-1:0] xsec [3][3],
    input  logic [TAG_W-1:0]     tag,
    output logic                 take,
    input  logic                 m_ready,
    output logic                 m_valid,
    output logic                 m_last,
    output logic signed [CW-1:0] out_x,
    output logic signed [CW-1:0] out_y,
    output logic signed [CW-1:0] out_z,
    output logic [SLOT_W-1:0]    vertex_slot,
    output logic [SIZE_W-1:0]    polygon_size,
    output logic [TAG_W-1:0]     material_out
);

    logic signed [CW-1:0] poly_next [4][3];
    logic [SIZE_W-1:0]    cnt_next;
    logic signed [CW-1:0] poly_reg  [4][3];
    logic [SIZE_W-1:0]    cnt_reg;
    logic [TAG_W-1:0]     tag_reg;
    logic [SLOT_W-1:0]    idx_reg;
    logic                 busy_reg;
    logic                 last;
    logic                 xfer;

    // Walk the edges in order and list the surviving vertices and crossing points
    always_comb begin
        cnt_next = '0;
        for (int m = 0; m < 4; m++) begin
            for (int k = 0; k < 3; k++) begin
                poly_next[m][k] = '0;
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (ctl.in_mask[i] && ctl.in_mask[(i+1)%3]) begin
                poly_next[cnt_next[1:0]] = vert[(i+1)%3];
                cnt_next = cnt_next + 3'd1;
            end else if (ctl.in_mask[i]) begin
                poly_next[cnt_next[1:0]] = xsec[i];
                cnt_next = cnt_next + 3'd1;
            end else if (ctl.in_mask[(i+1)%3]) begin
                poly_next[cnt_next[1:0]] = xsec[i];
                poly_next[2'(cnt_next + 3'd1)] = vert[(i+1)%3];
                cnt_next = cnt_next + 3'd2;
            end
        end
    end

    assign last = (cnt_reg == '0) || ({1'b0, idx_reg} == cnt_reg - 3'd1);
    assign xfer = busy_reg && m_ready;
    assign take = !busy_reg || (m_ready && last);

    // Load a new polygon, advance the slot, drop busy after the final word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (take && ctl.vld) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end else if (xfer && last) begin
            busy_reg <= 1'b0;
        end else if (xfer) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    // Polygon payload, no reset needed
    always_ff @(posedge aclk) begin
        if (take && ctl.vld) begin
            poly_reg <= poly_next;
            cnt_reg  <= cnt_next;
            tag_reg  <= tag;
        end
    end

    assign m_valid      = busy_reg;
    assign m_last       = last;
    assign out_x        = poly_reg[idx_reg][0];
    assign out_y        = poly_reg[idx_reg][1];
    assign out_z        = poly_reg[idx_reg][2];
    assign vertex_slot  = idx_reg;
    assign polygon_size = cnt_reg;
    assign material_out = tag_reg;

endmodule

>>> sv/triangle_plane_clipper.sv
// ----------------------------------------------------------------------------
// triangle_plane_clipper: clip one triangle against a configured plane
// Distance lanes, edge intersection lanes and a merge stage.
// ----------------------------------------------------------------------------
// Usage:
//   s_ side takes one triangle per word: nine Q4.16 coordinates and a
//   material tag. m_ side returns the clipped polygon one vertex per word,
//   slot and size attached, with m_tlast on the final vertex. A triangle
//   that lies fully outside yields one word of size 0.
//   The APB port sets the plane normal and offset; write it only while idle.
//   From accept to first result a triangle passes the input register, the
//   distance stages, the edge lane (magnitudes, split multiply, numerator
//   register, one quotient bit per stage for COORD_WIDTH + 1 stages,
//   saturation) and the merge register.
//   Throughput: one triangle per cycle while each yields one word and
//   m_tready is high; the serializer sends one word per cycle while m_tready
//   is high, and each triangle emits one to four words.
//   While a result word waits on m_tready, or more words of a polygon remain,
//   the whole pipeline holds and s_tready drops; the pipeline stages buffer
//   triangles meanwhile.
//   Reset clears the valid bits and the serializer and loads the register
//   reset values; no clearing pass is needed.
// ----------------------------------------------------------------------------
module triangle_plane_clipper
    import tpc_pkg::*;
#(
    parameter int COORD_WIDTH = 20
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, material_tag
    input  logic [((9*COORD_WIDTH+TAG_W+7)/8)*8-1:0] s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // out_x, out_y, out_z, vertex_slot, polygon_size, material_out
    output logic [((3*COORD_WIDTH+SLOT_W+SIZE_W+TAG_W+7)/8)*8-1:0] m_tdata,
    output logic                          m_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_W-1:0]             paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int CW  = COORD_WIDTH;
    localparam int DW  = CW + 26;
    localparam int LE  = CW + 5;
    localparam int NST = 3 + LE;
    localparam int MW  = ((3*CW+SLOT_W+SIZE_W+TAG_W+7)/8)*8;

    // Configuration registers
    logic signed [NRM_W-1:0] nrm_reg [3];
    logic signed [OFS_W-1:0] ofs_reg;
    logic                    cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nrm_reg[0] <= NORMAL_X_RST;
            nrm_reg[1] <= NORMAL_Y_RST;
            nrm_reg[2] <= NORMAL_Z_RST;
            ofs_reg    <= OFFSET_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_NORMAL_X: nrm_reg[0] <= pwdata[NRM_W-1:0];
                REG_NORMAL_Y: nrm_reg[1] <= pwdata[NRM_W-1:0];
                REG_NORMAL_Z: nrm_reg[2] <= pwdata[NRM_W-1:0];
                REG_OFFSET:   ofs_reg    <= pwdata[OFS_W-1:0];
                default:      ;
            endcase
        end
    end

    // Register readback, sign extended
    always_comb begin
        unique case (paddr[3:2])
            REG_NORMAL_X: prdata = 32'(nrm_reg[0]);
            REG_NORMAL_Y: prdata = 32'(nrm_reg[1]);
            REG_NORMAL_Z: prdata = 32'(nrm_reg[2]);
            REG_OFFSET:   prdata = 32'(ofs_reg);
            default:      prdata = '0;
        endcase
    end

    // Pipeline advance and valid chain
    logic           en;
    logic [NST-1:0] vld_reg;

    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], s_tvalid};
        end
    end

    // Input, product and distance stages for the vertex data
    logic signed [CW-1:0] va_reg [3][3];
    logic signed [CW-1:0] vp_reg [3][3];
    logic signed [CW-1:0] vd_reg [3][3];
    logic [TAG_W-1:0]     taga_reg;
    logic [TAG_W-1:0]     tagp_reg;
    logic [TAG_W-1:0]     tagd_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    va_reg[i][k] <= s_tdata[(3*i+k)*CW +: CW];
                end
            end
            taga_reg <= s_tdata[9*CW +: TAG_W];
            vp_reg   <= va_reg;
            tagp_reg <= taga_reg;
            vd_reg   <= vp_reg;
            tagd_reg <= tagp_reg;
        end
    end

    // Distance lanes
    logic signed [DW-1:0] dist_w [3];
    logic [2:0]           inside_d;

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_dist
        tpc_dist #(.CW(CW), .DW(DW)) u_dist (
            .aclk (aclk),
            .en   (en),
            .nrm  (nrm_reg),
            .ofs  (ofs_reg),
            .p    (va_reg[i]),
            .d    (dist_w[i])
        );
        assign inside_d[i] = (dist_w[i] <= 0);
    end

    // Edge lanes
    logic signed [CW-1:0] xsec [3][3];

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_edge
        tpc_edge #(.CW(CW), .DW(DW)) u_edge (
            .aclk (aclk),
            .en   (en),
            .a    (vd_reg[i]),
            .b    (vd_reg[(i+1)%3]),
            .da   (dist_w[i]),
            .db   (dist_w[(i+1)%3]),
            .x    (xsec[i])
        );
    end

    // Delay the vertices, tag and inside flags to meet the edge lanes
    logic signed [CW-1:0] dlv_reg   [LE][3][3];
    logic [TAG_W-1:0]     dltag_reg [LE];
    logic [2:0]           dlin_reg  [LE];

    always_ff @(posedge aclk) begin
        if (en) begin
            dlv_reg[0]   <= vd_reg;
            dltag_reg[0] <= tagd_reg;
            dlin_reg[0]  <= inside_d;
            for (int s = 1; s < LE; s++) begin
                dlv_reg[s]   <= dlv_reg[s-1];
                dltag_reg[s] <= dltag_reg[s-1];
                dlin_reg[s]  <= dlin_reg[s-1];
            end
        end
    end

    // Merge and serialize
    tpc_ctl_t             ctl;
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_y;
    logic signed [CW-1:0] out_z;
    logic [SLOT_W-1:0]    vertex_slot;
    logic [SIZE_W-1:0]    polygon_size;
    logic [TAG_W-1:0]     material_out;

    assign ctl.vld     = vld_reg[NST-1];
    assign ctl.in_mask = dlin_reg[LE-1];

    tpc_merge #(.CW(CW)) u_merge (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctl          (ctl),
        .vert         (dlv_reg[LE-1]),
        .xsec         (xsec),
        .tag          (dltag_reg[LE-1]),
        .take         (en),
        .m_ready      (m_tready),
        .m_valid      (m_tvalid),
        .m_last       (m_tlast),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_z        (out_z),
        .vertex_slot  (vertex_slot),
        .polygon_size (polygon_size),
        .material_out (material_out)
    );

    assign m_tdata = MW'({material_out, polygon_size, vertex_slot, out_z, out_y, out_x});

endmodule

>>> sv/tpc_checker.sv
// ----------------------------------------------------------------------------
// tpc_checker: port level checks of the clipper result stream
// Watches stall holding, slot sequencing, size bounds, the final word marking and reset behavior.
// ----------------------------------------------------------------------------
module tpc_checker
    import tpc_pkg::*;
#(
    parameter int COORD_WIDTH = 20
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic [((3*COORD_WIDTH+SLOT_W+SIZE_W+TAG_W+7)/8)*8-1:0] m_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic                          m_tlast
);

    localparam int SB = 3 * COORD_WIDTH;

    logic [SLOT_W-1:0] slot;
    logic [SIZE_W-1:0] size;

    assign slot = m_tdata[SB +: SLOT_W];
    assign size = m_tdata[SB+SLOT_W +: SIZE_W];

    // Stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // Slots of one polygon follow each other without a gap
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && (slot == $past(slot) + 2'd1) && (size == $past(size)))
        else $error("polygon slot sequence broken");

    // The final word carries the last slot, or slot 0 of an empty marker
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |->
            ((size == 3'd0) && (slot == 2'd0)) || ({1'b0, slot} == size - 3'd1))
        else $error("final word does not close the polygon");

    // Sizes stay within a clipped triangle
    a_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (size <= 3'd4) && ({1'b0, slot} < size || size == 3'd0))
        else $error("polygon size or slot out of range");

    // Nothing is offered right after reset
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind triangle_plane_clipper tpc_checker #(.COORD_WIDTH(COORD_WIDTH)) u_tpc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast)
);

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the triangle plane clipper
// Random and directed triangles go in through the stream port. A local model
// predicts every clipped vertex word, and the result stream is checked
// against it in order. Plane settings change through APB between phases.
// ----------------------------------------------------------------------------
module tb_top;
    import tpc_pkg::*;

    localparam int CW     = 20;
    localparam int SD_W   = ((9*CW+TAG_W+7)/8)*8;
    localparam int MD_W   = ((3*CW+SLOT_W+SIZE_W+TAG_W+7)/8)*8;
    localparam int LAT    = CW + 9;
    localparam int LIMIT  = 400000;

    typedef struct {
        logic signed [CW-1:0] v [9];
        logic [TAG_W-1:0]     tag;
    } tri_t;

    typedef struct {
        logic signed [CW-1:0] x, y, z;
        logic [SLOT_W-1:0]    slot;
        logic [SIZE_W-1:0]    size;
        logic [TAG_W-1:0]     tag;
        logic                 last;
    } vtx_t;

    logic               aclk = 0;
    logic               aresetn = 0;
    logic [SD_W-1:0]    s_tdata = '0;
    logic               s_tvalid = 0;
    logic               s_tready;
    logic [MD_W-1:0]    m_tdata;
    logic               m_tlast;
    logic               m_tvalid;
    logic               m_tready = 0;
    logic               psel = 0, penable = 0, pwrite = 0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    triangle_plane_clipper #(.COORD_WIDTH(CW)) dut (.*);

    // plane state of the local model
    logic signed [NRM_W-1:0] plane_n [3];
    logic signed [OFS_W-1:0] plane_ofs;

    tri_t   tri_q [$];
    vtx_t   vtx_q [$];
    int     errors = 0;
    int     cycles = 0;
    int     src_idle = 14, snk_idle = 66;
    int     hold_cycles = 0;
    bit     src_pause = 0;
    bit     in_acc = 0;

    initial forever #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("** triangle_plane_clipper: FAILED **");
            $finish;
        end
    end

    function automatic logic signed [63:0] plane_dist(input logic signed [CW-1:0] p [3]);
        logic signed [63:0] s;
        s = 0;
        for (int k = 0; k < 3; k++) s += 64'(plane_n[k]) * 64'(p[k]);
        return s - 64'(plane_ofs) * 65536;
    endfunction

    // intersection of a->b on one axis, quotient rounded half away from zero
    function automatic logic signed [CW-1:0] cross_axis(input logic signed [63:0] a,
            input logic signed [63:0] b, input logic signed [63:0] da,
            input logic signed [63:0] db);
        logic signed [63:0]  den, diff, r;
        logic [127:0]        num, ud;
        logic [127:0]        q;
        bit                  neg;
        den = da - db;
        if (den == 0) return a[CW-1:0];
        diff = b - a;
        neg = (diff < 0) != ((da < 0) != (den < 0));
        num = 128'(diff < 0 ? -diff : diff) * 128'(da < 0 ? -da : da);
        ud  = 128'(den < 0 ? -den : den);
        q = (2 * num + ud) / (2 * ud);
        if (q > (128'd1 << 40)) q = 128'd1 << 40;
        r = neg ? a - 64'(q) : a + 64'(q);
        if (r > (64'sd1 <<< (CW-1)) - 1) r = (64'sd1 <<< (CW-1)) - 1;
        if (r < -(64'sd1 <<< (CW-1))) r = -(64'sd1 <<< (CW-1));
        return r[CW-1:0];
    endfunction

    // clip one triangle and queue the polygon words it yields
    task automatic clip_triangle(input tri_t t);
        logic signed [CW-1:0] p [3][3];
        logic signed [63:0]   d [3];
        logic signed [CW-1:0] poly [4][3];
        int                   n, j;
        vtx_t                 w;
        n = 0;
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) p[i][k] = t.v[3*i+k];
            d[i] = plane_dist(p[i]);
        end
        for (int i = 0; i < 3; i++) begin
            j = (i + 1) % 3;
            if (d[i] > 0 || d[j] > 0) begin
                if ((d[i] <= 0 || d[j] <= 0) && n < 4) begin
                    for (int k = 0; k < 3; k++)
                        poly[n][k] = cross_axis(p[i][k], p[j][k], d[i], d[j]);
                    n++;
                end
            end
            if (d[j] <= 0 && n < 4) begin
                for (int k = 0; k < 3; k++) poly[n][k] = p[j][k];
                n++;
            end
        end
        w.tag = t.tag;
        if (n == 0) begin
            w.x = 0; w.y = 0; w.z = 0; w.slot = 0; w.size = 0; w.last = 1;
            vtx_q.push_back(w);
        end
        for (int i = 0; i < n; i++) begin
            w.x = poly[i][0]; w.y = poly[i][1]; w.z = poly[i][2];
            w.slot = SLOT_W'(i); w.size = SIZE_W'(n); w.last = (i == n - 1);
            vtx_q.push_back(w);
        end
    endtask

    // feed triangles; the model runs at the accept edge
    always @(negedge aclk) begin
        if (in_acc) begin
            void'(tri_q.pop_front());
        end
        if (aresetn && tri_q.size() > 0 && !src_pause && $urandom_range(99) >= src_idle) begin
            for (int i = 0; i < 9; i++) s_tdata[i*CW +: CW] <= tri_q[0].v[i];
            s_tdata[9*CW +: TAG_W] <= tri_q[0].tag;
            s_tvalid <= 1;
        end else if (!(s_tvalid && !in_acc)) begin
            s_tvalid <= 0;
        end
    end

    always @(posedge aclk) begin
        in_acc = s_tvalid && s_tready;
        if (in_acc) clip_triangle(tri_q[0]);
    end

    // receiver backpressure, with a long hold-off on demand
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 0;
        end else begin
            m_tready <= aresetn && ($urandom_range(99) >= snk_idle);
        end
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        errors++;
        $display("mismatch %s: got %0h want %0h", what, got, want);
    endtask

    // check each vertex word against the oldest expectation
    always @(posedge aclk) begin
        vtx_t w;
        if (m_tvalid && m_tready) begin
            if (vtx_q.size() == 0) begin
                report("unexpected word", 64'(m_tdata), 64'(0));
            end else begin
                w = vtx_q.pop_front();
                if (m_tdata[0 +: CW] !== w.x)
                    report("out_x", 64'(m_tdata[0 +: CW]), 64'(w.x));
                if (m_tdata[CW +: CW] !== w.y)
                    report("out_y", 64'(m_tdata[CW +: CW]), 64'(w.y));
                if (m_tdata[2*CW +: CW] !== w.z)
                    report("out_z", 64'(m_tdata[2*CW +: CW]), 64'(w.z));
                if (m_tdata[3*CW +: SLOT_W] !== w.slot)
                    report("vertex_slot", 64'(m_tdata[3*CW +: SLOT_W]), 64'(w.slot));
                if (m_tdata[3*CW+SLOT_W +: SIZE_W] !== w.size)
                    report("polygon_size", 64'(m_tdata[3*CW+SLOT_W +: SIZE_W]), 64'(w.size));
                if (m_tdata[3*CW+SLOT_W+SIZE_W +: TAG_W] !== w.tag)
                    report("material_out", 64'(m_tdata[3*CW+SLOT_W+SIZE_W +: TAG_W]),
                           64'(w.tag));
                if (m_tlast !== w.last) report("last", 64'(m_tlast), 64'(w.last));
            end
        end
    end

    task automatic reg_write(input logic [1:0] idx, input int value);
        @(negedge aclk);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= ADDR_W'(idx) << 2; pwdata <= value;
        @(negedge aclk);
        penable <= 1;
        @(negedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (idx == REG_OFFSET) plane_ofs = value[OFS_W-1:0];
        else plane_n[idx] = value[NRM_W-1:0];
    endtask

    task automatic drain;
        while (tri_q.size() > 0 || vtx_q.size() > 0) @(posedge aclk);
        repeat (LAT + 8) @(posedge aclk);
    endtask

    function automatic logic signed [CW-1:0] rnd_coord(input int mode);
        case (mode)
            0: return CW'($urandom);
            1: return $urandom_range(1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
            default: return CW'($signed($urandom_range(8*65536)) - 4*65536);
        endcase
    endfunction

    task automatic add_tri(input int mode);
        tri_t t;
        for (int i = 0; i < 9; i++) t.v[i] = rnd_coord(mode);
        t.tag = TAG_W'($urandom);
        tri_q.push_back(t);
    endtask

    task automatic add_fixed(input int a, b, c);
        tri_t t;
        for (int i = 0; i < 9; i++) t.v[i] = '0;
        t.v[1] = CW'(a); t.v[4] = CW'(b); t.v[7] = CW'(c);
        t.v[0] = CW'(65536); t.v[6] = CW'(-65536); t.v[5] = CW'(32768);
        t.tag = TAG_W'($urandom);
        tri_q.push_back(t);
    endtask

    task automatic set_plane(input int nx, ny, nz, ofs);
        reg_write(REG_NORMAL_X, nx);
        reg_write(REG_NORMAL_Y, ny);
        reg_write(REG_NORMAL_Z, nz);
        reg_write(REG_OFFSET, ofs);
    endtask

    initial begin
        tri_t t;
        plane_n[0] = NORMAL_X_RST; plane_n[1] = NORMAL_Y_RST;
        plane_n[2] = NORMAL_Z_RST; plane_ofs = OFFSET_RST;
        repeat (9) @(posedge aclk);
        @(negedge aclk) aresetn <= 1;

        // directed: plane y = 1 at reset; every inside/outside pattern
        for (int m = 0; m < 8; m++)
            add_fixed(m[0] ? 3*65536 : 0, m[1] ? 3*65536 : -65536, m[2] ? 2*65536 : 65536);
        add_fixed(65536, 65536, 65536);            // all on the plane
        add_fixed(-524288, 524287, -524288);       // coordinate extremes
        for (int i = 0; i < 9; i++) t.v[i] = {1'b0, {(CW-1){1'b1}}};
        t.tag = 16'hffff; tri_q.push_back(t);
        for (int i = 0; i < 9; i++) t.v[i] = {1'b1, {(CW-1){1'b0}}};
        t.tag = 16'h0000; tri_q.push_back(t);
        drain();

        // extreme plane: saturating intersections
        set_plane(65536, -65536, 65536, -524288);
        for (int i = 0; i < 6; i++) add_tri(1);
        drain();
        set_plane(-131072, 131071, -65536, 524287);
        for (int i = 0; i < 6; i++) add_tri(0);
        drain();

        // random phases with changing planes and idling patterns
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin src_idle = 66; snk_idle = 14; end
            if (ph == 4) begin src_idle = 0; snk_idle = 0; end
            set_plane($signed($urandom_range(131072)) - 65536,
                      $signed($urandom_range(131072)) - 65536,
                      $signed($urandom_range(131072)) - 65536,
                      $signed($urandom_range(262144)) - 131072);
            if (ph == 1) hold_cycles = 300;
            for (int i = 0; i < 65; i++) add_tri($urandom_range(9) == 0 ? 0 : 2);
            if (ph == 3) begin
                while (tri_q.size() > 30) @(posedge aclk);
                src_pause = 1;
                while (vtx_q.size() > 0) @(posedge aclk);
                src_pause = 0;
            end
            drain();
        end

        if (errors == 0) begin
            $display("** triangle_plane_clipper: PASSED **");
        end else begin
            $display("** triangle_plane_clipper: FAILED **");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/tpc_pkg.sv
sv/tpc_dist.sv
sv/tpc_edge.sv
sv/tpc_merge.sv
sv/triangle_plane_clipper.sv
sv/tpc_checker.sv
dv/tb_top.sv
